FILE: hw/rtl/assert_macros.svh
// Assertion helpers used by pip_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PIP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define PIP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

FILE: hw/rtl/pip_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types and codes of the point-in-polygon classifier.
// ----------------------------------------------------------------------------
package pip_pkg;

   localparam int SLOT_BITS     = 10;
   localparam int COUNT_BITS    = 11;
   localparam int CLASS_BITS    = 2;
   localparam int RSP_DATA_BITS = 8;

   // request kinds carried on req_tuser
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // location classes
   localparam logic [CLASS_BITS-1:0] CLASS_INTERIOR = 2'd0;
   localparam logic [CLASS_BITS-1:0] CLASS_EXTERIOR = 2'd1;
   localparam logic [CLASS_BITS-1:0] CLASS_VERTEX   = 2'd2;
   localparam logic [CLASS_BITS-1:0] CLASS_EDGE     = 2'd3;

   // controller to datapath commands
   typedef struct packed {
      logic wr_en;      // store the request vertex
      logic rd_en;      // read one vertex
      logic rd_first;   // read primes the previous vertex only
      logic q_load;     // latch the query point
      logic acc_clear;  // clear parities and hit flag
      logic rsp_load;   // capture the class into the response register
   } ctrl_cmd_type;

endpackage

FILE: hw/rtl/point_in_polygon_classify_unit.sv
`timescale 1ns / 1ps
// Sequence: after a query is accepted, the unit reads the last vertex, then walks the
//   n edge reads, waits for the edge pipeline to go idle and then loads the response;
//   an empty polygon skips the reads. Vertex loads leave the unit idle, back to back.
// Requests are taken only while idle: a query is finished, its response load waiting
//   while the previous response is held, before the next request is taken.
// Reset: clears the sequencer, the response valid and vertex_count; the vertex
//   store is not cleared and holds garbage until loaded.
// ----------------------------------------------------------------------------
// point_in_polygon_classify_unit
// Crossing-number point-in-polygon classifier with vertex and edge detection.
// ----------------------------------------------------------------------------
module point_in_polygon_classify_unit
   import pip_pkg::*;
#(
   parameter int MAX_VERTICES = 1024,
   parameter int COORD_BITS   = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // vertex_slot, coord_x, coord_y, zero padding
   input  logic [((SLOT_BITS + 2 * COORD_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   // command
   input  logic [0:0]            req_tuser,
   input  logic                  csr_wr_en,
   input  logic [COUNT_BITS-1:0] csr_wr_data,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // location_class, zero padding
   output logic [RSP_DATA_BITS-1:0] rsp_tdata
);

   localparam int AW = $clog2(MAX_VERTICES);

   ctrl_cmd_type          cmd;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic                  pipe_busy;
   logic [CLASS_BITS-1:0] location_class;

   pip_ctrl #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_command (req_tuser[0]),
      .req_slot    (req_tdata[SLOT_BITS-1:0]),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .cmd         (cmd),
      .wr_addr     (wr_addr),
      .rd_addr     (rd_addr),
      .pipe_busy   (pipe_busy)
   );

   pip_datapath #(
      .MAX_VERTICES (MAX_VERTICES),
      .COORD_BITS   (COORD_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .wr_addr        (wr_addr),
      .rd_addr        (rd_addr),
      .coord_x        (req_tdata[SLOT_BITS +: COORD_BITS]),
      .coord_y        (req_tdata[SLOT_BITS + COORD_BITS +: COORD_BITS]),
      .pipe_busy      (pipe_busy),
      .location_class (location_class)
   );

   assign rsp_tdata = {{(RSP_DATA_BITS - CLASS_BITS){1'b0}}, location_class};

endmodule

FILE: hw/rtl/pip_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pip_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/pip_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_datapath
// Vertex store and the edge pipeline: offset, cross products, parity update.
// ----------------------------------------------------------------------------
module pip_datapath
   import pip_pkg::*;
#(
   parameter int MAX_VERTICES = 1024,
   parameter int COORD_BITS   = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  ctrl_cmd_type                    cmd,
   input  logic [$clog2(MAX_VERTICES)-1:0] wr_addr,
   input  logic [$clog2(MAX_VERTICES)-1:0] rd_addr,
   input  logic [COORD_BITS-1:0]           coord_x,
   input  logic [COORD_BITS-1:0]           coord_y,
   output logic                            pipe_busy,
   output logic [CLASS_BITS-1:0]           location_class
);

   localparam int AW   = $clog2(MAX_VERTICES);
   localparam int DW   = COORD_BITS + 1;
   localparam int PW   = 2 * DW;
   localparam int NUMW = PW + 1;

   logic [2*COORD_BITS-1:0] rd_data;

   logic signed [COORD_BITS-1:0] q_x_ff, q_x_in, q_y_ff, q_y_in;

   logic s1_vld_ff, s1_first_ff;
   logic s2_vld_ff, s3_vld_ff;

   logic signed [DW-1:0] off_x, off_y;
   logic signed [DW-1:0] cur_x_ff, cur_y_ff, prv_x_ff, prv_y_ff;

   logic signed [PW-1:0] prod_a_ff, prod_a_in, prod_b_ff, prod_b_in;
   logic hit_ff, hit_in, str_r_ff, str_r_in, str_l_ff, str_l_in;
   logic den_neg_ff, den_neg_in;

   logic signed [NUMW-1:0] num;
   logic num_zero, num_neg;
   logic rpar_ff, rpar_in, lpar_ff, lpar_in, hit_any_ff, hit_any_in;

   logic [CLASS_BITS-1:0] class_code, class_ff;

   pip_ram #(
      .WIDTH (2 * COORD_BITS),
      .DEPTH (MAX_VERTICES)
   ) u_vertex_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data ({coord_y, coord_x}),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr[AW-1:0]),
      .rd_data (rd_data)
   );

   // query point
   assign q_x_in = cmd.q_load ? signed'(coord_x) : q_x_ff;
   assign q_y_in = cmd.q_load ? signed'(coord_y) : q_y_ff;

   always_ff @(posedge clock) begin
      q_x_ff <= q_x_in;
      q_y_ff <= q_y_in;
   end

   // stage 1 tags follow the registered RAM read
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff   <= 1'b0;
         s1_first_ff <= 1'b0;
         s2_vld_ff   <= 1'b0;
         s3_vld_ff   <= 1'b0;
      end else begin
         s1_vld_ff   <= cmd.rd_en;
         s1_first_ff <= cmd.rd_first;
         s2_vld_ff   <= s1_vld_ff & ~s1_first_ff;
         s3_vld_ff   <= s2_vld_ff;
      end
   end

   // stage 2: vertex relative to the query, keep previous one alongside
   assign off_x = {rd_data[COORD_BITS-1], rd_data[COORD_BITS-1:0]}
                - {q_x_ff[COORD_BITS-1], q_x_ff};
   assign off_y = {rd_data[2*COORD_BITS-1], rd_data[2*COORD_BITS-1:COORD_BITS]}
                - {q_y_ff[COORD_BITS-1], q_y_ff};

   always_ff @(posedge clock) begin
      if (s1_vld_ff) begin
         cur_x_ff <= off_x;
         cur_y_ff <= off_y;
         prv_x_ff <= cur_x_ff;
         prv_y_ff <= cur_y_ff;
      end
   end

   // stage 3: cross product terms and crossing conditions
   assign prod_a_in  = cur_x_ff * prv_y_ff;
   assign prod_b_in  = prv_x_ff * cur_y_ff;
   assign hit_in     = (cur_x_ff == '0) && (cur_y_ff == '0);
   assign str_r_in   = (!cur_y_ff[DW-1] && cur_y_ff != '0)
                    != (!prv_y_ff[DW-1] && prv_y_ff != '0);
   assign str_l_in   = cur_y_ff[DW-1] != prv_y_ff[DW-1];
   assign den_neg_in = prv_y_ff < cur_y_ff;

   always_ff @(posedge clock) begin
      prod_a_ff  <= prod_a_in;
      prod_b_ff  <= prod_b_in;
      hit_ff     <= hit_in;
      str_r_ff   <= str_r_in;
      str_l_ff   <= str_l_in;
      den_neg_ff <= den_neg_in;
   end

   // stage 4: sign of the cross product against sign of the y difference
   assign num      = {prod_a_ff[PW-1], prod_a_ff} - {prod_b_ff[PW-1], prod_b_ff};
   assign num_zero = (num == '0);
   assign num_neg  = num[NUMW-1];

   always_comb begin
      rpar_in    = rpar_ff;
      lpar_in    = lpar_ff;
      hit_any_in = hit_any_ff;
      if (cmd.acc_clear) begin
         rpar_in    = 1'b0;
         lpar_in    = 1'b0;
         hit_any_in = 1'b0;
      end else if (s3_vld_ff) begin
         hit_any_in = hit_any_ff | hit_ff;
         if (str_r_ff && !num_zero && (num_neg == den_neg_ff)) begin
            rpar_in = ~rpar_ff;
         end
         if (str_l_ff && !num_zero && (num_neg != den_neg_ff)) begin
            lpar_in = ~lpar_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rpar_ff    <= 1'b0;
         lpar_ff    <= 1'b0;
         hit_any_ff <= 1'b0;
      end else begin
         rpar_ff    <= rpar_in;
         lpar_ff    <= lpar_in;
         hit_any_ff <= hit_any_in;
      end
   end

   always_comb begin
      priority if (hit_any_ff) begin
         class_code = CLASS_VERTEX;
      end else if (rpar_ff != lpar_ff) begin
         class_code = CLASS_EDGE;
      end else if (rpar_ff) begin
         class_code = CLASS_INTERIOR;
      end else begin
         class_code = CLASS_EXTERIOR;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         class_ff <= class_code;
      end
   end

   assign pipe_busy      = s1_vld_ff | s2_vld_ff | s3_vld_ff;
   assign location_class = class_ff;

endmodule

FILE: hw/rtl/pip_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_ctrl
// Request handshake, vertex count register and the edge walk sequencer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pip_ctrl
   import pip_pkg::*;
#(
   parameter int MAX_VERTICES = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic                            req_command,
   input  logic [SLOT_BITS-1:0]            req_slot,
   input  logic                            csr_wr_en,
   input  logic [COUNT_BITS-1:0]           csr_wr_data,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output ctrl_cmd_type                    cmd,
   output logic [$clog2(MAX_VERTICES)-1:0] wr_addr,
   output logic [$clog2(MAX_VERTICES)-1:0] rd_addr,
   input  logic                            pipe_busy
);

   localparam int AW = $clog2(MAX_VERTICES);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_PRIME  = 5'b00010,
      ST_WALK   = 5'b00100,
      ST_DRAIN  = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [AW-1:0] last_ff, last_in, idx_ff, idx_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic accept;
   logic [31:0] slot_ext, count_ext, n_sat, last_ext;

   assign accept    = req_tvalid & req_tready;
   assign slot_ext  = 32'(req_slot);
   assign count_ext = 32'(count_ff);
   assign n_sat     = (count_ext > 32'(MAX_VERTICES)) ? 32'(MAX_VERTICES) : count_ext;
   assign last_ext  = n_sat - 32'd1;

   assign count_in = csr_wr_en ? csr_wr_data : count_ff;

   always_comb begin
      state_in     = state_ff;
      last_in      = last_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      cmd          = '0;
      req_tready   = 1'b0;
      rd_addr      = idx_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (accept) begin
               if (req_command == CMD_QUERY) begin
                  cmd.q_load    = 1'b1;
                  cmd.acc_clear = 1'b1;
                  last_in       = last_ext[AW-1:0];
                  idx_in        = '0;
                  // empty polygon: nothing to walk
                  state_in      = (count_ff == '0) ? ST_DRAIN : ST_PRIME;
               end else begin
                  cmd.wr_en = (slot_ext < 32'(MAX_VERTICES));
               end
            end
         end
         ST_PRIME: begin
            // last vertex first, as the predecessor of vertex 0
            cmd.rd_en    = 1'b1;
            cmd.rd_first = 1'b1;
            rd_addr      = last_ff;
            state_in     = ST_WALK;
         end
         ST_WALK: begin
            cmd.rd_en = 1'b1;
            if (idx_ff == last_ff) begin
               state_in = ST_DRAIN;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!pipe_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff <= last_in;
      idx_ff  <= idx_in;
   end

   assign wr_addr    = slot_ext[AW-1:0];
   assign rsp_tvalid = rsp_valid_ff;

   `PIP_ASSERT_NEXT(a_query_leaves_idle, clock, reset, accept && req_command == CMD_QUERY, !req_tready)
   `PIP_ASSERT_SAME(a_rsp_after_drain, clock, reset, cmd.rsp_load, !pipe_busy)
   `PIP_ASSERT_SAME(a_rsp_from_finish, clock, reset, $rose(rsp_valid_ff), $past(state_ff == ST_FINISH))

endmodule
